FILE: hdl/csi_pkg.sv
// Shared types and constants for the calendar one-second increment pipeline.
// Holds the transfer payload structs and the stage records; no dependencies.
`timescale 1ns / 1ps

package csi_pkg;

  localparam int unsigned YEAR_BITS = 14;

  typedef struct packed {
    logic [5:0]           second_in;
    logic [5:0]           minute_in;
    logic [4:0]           hour_in;
    logic [4:0]           day_in;
    logic [3:0]           month_in;
    logic [YEAR_BITS-1:0] year_in;
  } csi_in_t;

  typedef struct packed {
    logic [5:0]           second_out;
    logic [5:0]           minute_out;
    logic [4:0]           hour_out;
    logic [4:0]           day_out;
    logic [3:0]           month_out;
    logic [YEAR_BITS-1:0] year_out;
  } csi_out_t;

  // after stage 1: field limits decoded, year scaled for the divide-by-25 test
  typedef struct packed {
    csi_in_t              cur;
    logic                 sec_end;
    logic                 min_end;
    logic                 hr_end;
    logic                 mon_feb;
    logic                 mon_dec;
    logic                 div4;
    logic                 div16;
    logic [4:0]           mon_len;
    logic [YEAR_BITS-1:0] year_prod;
  } csi_s1_t;

  // after stage 2: month length resolved against the day
  typedef struct packed {
    csi_in_t cur;
    logic    sec_end;
    logic    min_end;
    logic    hr_end;
    logic    mon_dec;
    logic    day_last;
  } csi_s2_t;

endpackage

FILE: hdl/calendar_second_increment_unit.sv
// Advances a Gregorian date and time by one second. One transfer is taken per cycle while
// in_stall_o is low, and each passes the three register stages in order: limit decode
// and the year multiply for the divide-by-25 test, then the leap and month-length compare,
// then carry selection into the output register. Out-of-range fields simply increment and
// wrap at their width; the year wraps at csi_pkg::YEAR_BITS bits. A stall at the output
// backs up stage by stage, so up to three items are held and none is lost.
// Depends on csi_pkg, csi_prep, csi_len and csi_sel.
`timescale 1ns / 1ps

module calendar_second_increment_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csi_pkg::csi_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csi_pkg::csi_out_t out_data_o
);
  import csi_pkg::*;

  logic    s1_valid, s2_valid;
  logic    s1_ready, s2_ready, s3_ready;
  csi_s1_t s1_data;
  csi_s2_t s2_data;

  csi_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .ready_i (s2_ready),
    .ready_o (s1_ready),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  csi_len u_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_i (s3_ready),
    .ready_o (s2_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  csi_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_i (~out_stall_i),
    .ready_o (s3_ready),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  assign in_stall_o = ~s1_ready;

`ifndef NO_ASSERTIONS
  // input backs up only with every stage full and the output stalled
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid && out_valid_o && out_stall_i))
    else $error("input stalled with a free pipeline stage");

  a_s3_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && s3_ready) |=> out_valid_o)
    else $error("stage 2 item lost on its way to the output");

  a_sec_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && s3_ready && s2_data.cur.second_in != 6'd59) |=>
      (out_data_o.second_out == $past(s2_data.cur.second_in) + 6'd1))
    else $error("second not advanced by one");
`endif

endmodule

FILE: hdl/csi_prep.sv
// Stage 1: decodes field limits, month table and year residues.
// Depends on csi_pkg.
`timescale 1ns / 1ps

module csi_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csi_pkg::csi_in_t  data_i,
  input  logic              ready_i,
  output logic              ready_o,
  output logic              valid_o,
  output csi_pkg::csi_s1_t  data_o
);
  import csi_pkg::*;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  // multiplicative inverse of 25 modulo 2^16
  localparam logic [15:0] INV25_16 = 16'h5C29;
  localparam logic [YEAR_BITS-1:0] INV25 = INV25_16[YEAR_BITS-1:0];

  function automatic logic [4:0] month_days(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  logic    valid_q;
  csi_s1_t data_d, data_q;

  always_comb begin
    data_d.cur       = data_i;
    data_d.sec_end   = (data_i.second_in == 6'd59);
    data_d.min_end   = (data_i.minute_in == 6'd59);
    data_d.hr_end    = (data_i.hour_in == 5'd23);
    data_d.mon_feb   = (data_i.month_in == MONTH_FEB);
    data_d.mon_dec   = (data_i.month_in == MONTH_DEC);
    data_d.div4      = (data_i.year_in[1:0] == 2'd0);
    data_d.div16     = (data_i.year_in[3:0] == 4'd0);
    data_d.mon_len   = month_days(data_i.month_in);
    data_d.year_prod = data_i.year_in * INV25;
  end

  assign ready_o = ready_i | ~valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/csi_len.sv
// Stage 2: leap-year decision and last-day-of-month compare.
// Depends on csi_pkg.
`timescale 1ns / 1ps

module csi_len (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csi_pkg::csi_s1_t  data_i,
  input  logic              ready_i,
  output logic              ready_o,
  output logic              valid_o,
  output csi_pkg::csi_s2_t  data_o
);
  import csi_pkg::*;

  // year * inv(25) mod 2^n falls at or below this bound exactly for multiples of 25
  localparam logic [YEAR_BITS-1:0] DIV25_MAX = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);
  localparam logic [4:0] LEAP_FEB_LEN = 5'd29;

  logic       valid_q;
  csi_s2_t    data_d, data_q;
  logic       div25, leap;
  logic [4:0] dim;

  always_comb begin
    div25 = (data_i.year_prod <= DIV25_MAX);
    leap  = data_i.div4 & (~div25 | data_i.div16);
    dim   = (data_i.mon_feb && leap) ? LEAP_FEB_LEN : data_i.mon_len;
    data_d.cur      = data_i.cur;
    data_d.sec_end  = data_i.sec_end;
    data_d.min_end  = data_i.min_end;
    data_d.hr_end   = data_i.hr_end;
    data_d.mon_dec  = data_i.mon_dec;
    data_d.day_last = (data_i.cur.day_in == dim);
  end

  assign ready_o = ready_i | ~valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/csi_sel.sv
// Stage 3: field increments, carry selection and output register.
// Depends on csi_pkg.
`timescale 1ns / 1ps

module csi_sel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csi_pkg::csi_s2_t  data_i,
  input  logic              ready_i,
  output logic              ready_o,
  output logic              valid_o,
  output csi_pkg::csi_out_t data_o
);
  import csi_pkg::*;

  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [3:0] MONTH_JAN = 4'd1;

  logic     valid_q;
  csi_out_t data_d, data_q;
  logic     roll_hr, roll_day;

  always_comb begin
    roll_hr  = data_i.sec_end & data_i.min_end;
    roll_day = roll_hr & data_i.hr_end;

    data_d.second_out = data_i.sec_end ? 6'd0 : data_i.cur.second_in + 6'd1;
    data_d.minute_out = data_i.cur.minute_in;
    if (data_i.sec_end) begin
      data_d.minute_out = data_i.min_end ? 6'd0 : data_i.cur.minute_in + 6'd1;
    end
    data_d.hour_out = data_i.cur.hour_in;
    if (roll_hr) begin
      data_d.hour_out = data_i.hr_end ? 5'd0 : data_i.cur.hour_in + 5'd1;
    end

    data_d.day_out   = data_i.cur.day_in;
    data_d.month_out = data_i.cur.month_in;
    data_d.year_out  = data_i.cur.year_in;
    if (roll_day) begin
      if (!data_i.day_last) begin
        data_d.day_out = data_i.cur.day_in + 5'd1;
      end else if (data_i.mon_dec) begin
        data_d.day_out   = DAY_FIRST;
        data_d.month_out = MONTH_JAN;
        data_d.year_out  = data_i.cur.year_in + YEAR_BITS'(1);
      end else begin
        data_d.day_out   = DAY_FIRST;
        data_d.month_out = data_i.cur.month_in + 4'd1;
      end
    end
  end

  assign ready_o = ready_i | ~valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: tb/date_advance_checker.sv
// Watches both transfer channels of the one-second calendar increment, predicts each
// result from the accepted date and compares field by field. Depends on csi_pkg.
`timescale 1ns / 1ps

module date_advance_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  csi_pkg::csi_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  csi_pkg::csi_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import csi_pkg::*;

  localparam logic [3:0] FEBRUARY = 4'd2;
  localparam logic [3:0] DECEMBER = 4'd12;

  csi_out_t    expected_dates[$];
  int unsigned mismatches = 0;

  function automatic bit is_leap(logic [YEAR_BITS-1:0] year);
    int unsigned y;
    y = year;
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [4:0] month_length(logic [3:0] month, logic [YEAR_BITS-1:0] year);
    if (month == FEBRUARY) begin
      return is_leap(year) ? 5'd29 : 5'd28;
    end
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  function automatic csi_out_t next_second_date(csi_in_t d);
    csi_out_t r;
    r.second_out = d.second_in + 6'd1;
    r.minute_out = d.minute_in;
    r.hour_out   = d.hour_in;
    r.day_out    = d.day_in;
    r.month_out  = d.month_in;
    r.year_out   = d.year_in;
    if (r.second_out == 6'd60) begin
      r.second_out = '0;
      r.minute_out = d.minute_in + 6'd1;
      if (r.minute_out == 6'd60) begin
        r.minute_out = '0;
        r.hour_out   = d.hour_in + 5'd1;
        if (r.hour_out == 5'd24) begin
          r.hour_out = '0;
          if (d.day_in != month_length(d.month_in, d.year_in)) begin
            r.day_out = d.day_in + 5'd1;
          end else if (d.month_in == DECEMBER) begin
            r.day_out   = 5'd1;
            r.month_out = 4'd1;
            r.year_out  = d.year_in + YEAR_BITS'(1);
          end else begin
            r.day_out   = 5'd1;
            r.month_out = d.month_in + 4'd1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic bit field_differs(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
    return want != got;
  endfunction

  always @(posedge clk_i) begin
    csi_out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result transfer expected none, got %p", $time, out_data_i);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          if (field_differs("second", want.second_out, out_data_i.second_out) |
              field_differs("minute", want.minute_out, out_data_i.minute_out) |
              field_differs("hour",   want.hour_out,   out_data_i.hour_out)   |
              field_differs("day",    want.day_out,    out_data_i.day_out)    |
              field_differs("month",  want.month_out,  out_data_i.month_out)  |
              field_differs("year",   want.year_out,   out_data_i.year_out)) begin
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_dates.push_back(next_second_date(in_data_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_dates.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Top of the one-second calendar increment testbench: clock, reset, date stimulus with
// random idling and back-pressure, and the verdict. Depends on csi_pkg,
// calendar_second_increment_unit and date_advance_checker.
`timescale 1ns / 1ps

module tb;
  import csi_pkg::*;

  localparam int unsigned RANDOM_DATES = 1250;
  localparam int unsigned TOTAL_DATES  = RANDOM_DATES + 24;
  localparam int unsigned LONG_HOLD    = 60;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  csi_in_t     in_data_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  csi_out_t    out_data_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  calendar_second_increment_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  date_advance_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // idling pauses every third window of 128 transfers and over the tail of the run
  function automatic bit calm_phase(int unsigned count);
    return ((count / 128) % 3 == 2) || (count + 160 >= TOTAL_DATES);
  endfunction

  function automatic csi_in_t date_of(int unsigned sec, int unsigned mnt, int unsigned hr,
                                      int unsigned day, int unsigned mon, int unsigned yr);
    csi_in_t d;
    d.second_in = 6'(sec);
    d.minute_in = 6'(mnt);
    d.hour_in   = 5'(hr);
    d.day_in    = 5'(day);
    d.month_in  = 4'(mon);
    d.year_in   = YEAR_BITS'(yr);
    return d;
  endfunction

  // biased towards rollovers and leap-rule years, with some out-of-range fields
  function automatic csi_in_t random_date();
    csi_in_t     d;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    d.second_in = (pick < 6) ? 6'd59 : (pick < 9) ? 6'($urandom_range(0, 59))
                                                  : 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 9);
    d.minute_in = (pick < 6) ? 6'd59 : (pick < 9) ? 6'($urandom_range(0, 59))
                                                  : 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 9);
    d.hour_in   = (pick < 6) ? 5'd23 : (pick < 9) ? 5'($urandom_range(0, 23))
                                                  : 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    d.day_in    = (pick < 5) ? 5'($urandom_range(28, 31)) : (pick < 9) ? 5'($urandom_range(1, 31))
                                                                       : 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    d.month_in  = (pick < 9) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 4))
      0:       d.year_in = YEAR_BITS'(4 * $urandom_range(0, 4095));
      1:       d.year_in = YEAR_BITS'(100 * $urandom_range(0, 163));
      2:       d.year_in = YEAR_BITS'(400 * $urandom_range(0, 40));
      3:       d.year_in = '1;
      default: d.year_in = YEAR_BITS'($urandom_range(0, 16383));
    endcase
    return d;
  endfunction

  task automatic send_date(csi_in_t d);
    if (!calm_phase(sent_count) && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    sent_count <= sent_count + 1;
  endtask

  // receiver: random stall bursts, plus two long hold-offs to fill the pipeline
  initial begin
    int unsigned long_holds;
    long_holds = 0;
    forever begin
      @(posedge clk_i);
      if (long_holds < 2 && sent_count >= 400 + 500 * long_holds) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_holds++;
      end else if (!calm_phase(sent_count) && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    csi_in_t directed_dates[$];
    directed_dates.push_back(date_of(0, 0, 0, 1, 1, 2000));
    directed_dates.push_back(date_of(58, 30, 12, 15, 6, 2021));
    directed_dates.push_back(date_of(59, 30, 12, 15, 6, 2021));
    directed_dates.push_back(date_of(59, 59, 12, 15, 6, 2021));
    directed_dates.push_back(date_of(59, 59, 23, 15, 6, 2021));
    directed_dates.push_back(date_of(59, 59, 23, 31, 1, 2021));
    directed_dates.push_back(date_of(59, 59, 23, 28, 2, 2023));
    directed_dates.push_back(date_of(59, 59, 23, 28, 2, 2024));
    directed_dates.push_back(date_of(59, 59, 23, 29, 2, 2024));
    directed_dates.push_back(date_of(59, 59, 23, 28, 2, 1900));
    directed_dates.push_back(date_of(59, 59, 23, 28, 2, 2000));
    directed_dates.push_back(date_of(59, 59, 23, 28, 2, 0));
    directed_dates.push_back(date_of(59, 59, 23, 30, 4, 2022));
    directed_dates.push_back(date_of(59, 59, 23, 31, 12, 2023));
    directed_dates.push_back(date_of(59, 59, 23, 31, 12, 16383));
    // out-of-range fields: wrap without carry, or increment past the limit
    directed_dates.push_back(date_of(63, 10, 10, 10, 10, 10));
    directed_dates.push_back(date_of(60, 10, 10, 10, 10, 10));
    directed_dates.push_back(date_of(59, 63, 10, 10, 10, 10));
    directed_dates.push_back(date_of(59, 59, 31, 10, 10, 10));
    directed_dates.push_back(date_of(59, 59, 23, 31, 0, 2001));
    directed_dates.push_back(date_of(59, 59, 23, 31, 15, 2001));
    directed_dates.push_back(date_of(59, 59, 23, 31, 4, 2001));
    directed_dates.push_back(date_of(59, 59, 23, 0, 13, 2001));
    directed_dates.push_back(date_of(63, 63, 31, 31, 15, 16383));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_dates[i]) send_date(directed_dates[i]);
    repeat (RANDOM_DATES) send_date(random_date());
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/csi_pkg.sv
hdl/csi_prep.sv
hdl/csi_len.sv
hdl/csi_sel.sv
hdl/calendar_second_increment_unit.sv
tb/date_advance_checker.sv
tb/tb.sv
